FILE: src/refract_direction_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the refraction direction unit
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFRACT_DIRECTION_UNIT_ASSERT_SVH
`define REFRACT_DIRECTION_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RDU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RDU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RDU_ASSERT_IMP(label, ante, cons, msg)
`define RDU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: src/rdu_pkg.sv
// ----------------------------------------------------------------------------
// rdu_pkg
// Constants, pipeline stage map and shared helpers of the refraction unit.
// ----------------------------------------------------------------------------
package rdu_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam logic [15:0] RATIO_RESET = 16'd24576;
    localparam logic [15:0] ETA_MAX     = 16'hFFFF;
    localparam logic [15:0] WEIGHT_MAX  = 16'hFFFF;

    // stage map
    localparam int ST_PROD    = 0;
    localparam int ST_DOT     = 1;
    localparam int ST_COS     = 2;
    localparam int ST_SQR     = 3;
    localparam int ST_SIN     = 4;
    localparam int ST_PWR     = 5;
    localparam int ST_TIR     = 6;
    localparam int ST_CT      = 7;
    localparam int CT_STEPS   = 8;
    localparam int ST_KVAL    = ST_CT + CT_STEPS;
    localparam int ST_VMUL    = ST_KVAL + 1;
    localparam int ST_VSUM    = ST_VMUL + 1;
    localparam int ST_MAG     = ST_VSUM + 1;
    localparam int ST_SHAMT   = ST_MAG + 1;
    localparam int ST_SHIFT   = ST_SHAMT + 1;
    localparam int ST_SQUARE  = ST_SHIFT + 1;
    localparam int ST_LEN2    = ST_SQUARE + 1;
    localparam int ST_LEN     = ST_LEN2 + 1;
    localparam int LEN_STEPS  = 16;
    localparam int ST_QINIT   = ST_LEN + LEN_STEPS;
    localparam int ST_QDIV    = ST_QINIT + 1;
    localparam int QDIV_STEPS = 8;
    localparam int ST_OUT     = ST_QDIV + QDIV_STEPS;
    localparam int NSTG       = ST_OUT + 1;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    // one digit of a restoring square root
    function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
        logic [35:0] r;
        logic [35:0] trial;
        sqrt_t       o;
        r     = {s.rem, pair};
        trial = {2'b00, s.root, 2'b01};
        if (r >= trial)
        begin
            o.rem  = 34'(r - trial);
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = 34'(r);
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

FILE: src/rdu_ifs.sv
// ----------------------------------------------------------------------------
// rdu channel interfaces
// Ray input, scatter result and ratio write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface rdu_ray_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] incoming_x;
    logic signed [15:0] incoming_y;
    logic signed [15:0] incoming_z;

    modport source (output valid, normal_x, normal_y, normal_z,
                    incoming_x, incoming_y, incoming_z, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z,
                    incoming_x, incoming_y, incoming_z, output ready);
endinterface

interface rdu_scatter_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic        [15:0] weight;
    logic        [14:0] density;
    logic               internal_reflect;
    logic               entering_flag;

    modport source (output valid, out_x, out_y, out_z, weight, density,
                    internal_reflect, entering_flag, input ready);
    modport sink   (input valid, out_x, out_y, out_z, weight, density,
                    internal_reflect, entering_flag, output ready);
endinterface

interface rdu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] index_ratio;

    modport source (output valid, index_ratio, input ready);
    modport sink   (input valid, index_ratio, output ready);
endinterface

FILE: src/refract_direction_unit.sv
// ----------------------------------------------------------------------------
// refract_direction_unit
// Snell refraction / mirror reflection of a unit ray at a surface, Q1.14.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+------------------
//  ray      | in  | normal_x/y/z, incoming_x/y/z              | valid & ready
//  scatter  | out | out_x/y/z, weight, density, flags         | valid & ready
//  cfg      | in  | index_ratio                               | valid & ready
//
//  One ray per cycle while the output does not stall and the divider is idle;
//  fixed-depth pipeline, NSTG stages. Reset clears all stage valids, then the
//  1/ratio divider runs (load, then 16 quotient bits); ray.ready is low during
//  that time, and again after every ratio write until the divider is idle.
//  A stalled scatter transfer freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
module refract_direction_unit (
    input  logic               clk,
    input  logic               rst_n,
    rdu_ray_if.sink            ray,
    rdu_scatter_if.source      scatter,
    rdu_cfg_if.sink            cfg
);

`include "refract_direction_unit_assert.svh"

    // per-item pipeline payload; fields are filled as the item moves down
    typedef struct packed {
        logic [2:0][15:0] n;
        logic [2:0][15:0] w;
        logic [2:0][31:0] prod;
        logic [33:0]      d;
        logic             entering;
        logic [14:0]      c;
        logic [15:0]      eta;
        logic [28:0]      cc;
        logic [31:0]      eta2;
        logic [15:0]      ec;
        logic [14:0]      s1;
        logic [46:0]      p;
        logic             tir;
        logic [63:0]      sq_arg;
        rdu_pkg::sqrt_t   sq;
        logic [47:0]      w_rem;
        logic [15:0]      w_q;
        logic             w_sat;
        logic [17:0]      k;
        logic [2:0][32:0] ew;
        logic [2:0][33:0] kn;
        logic [2:0][49:0] dn;
        logic [2:0][50:0] t;
        logic [2:0][49:0] mag;
        logic [2:0]       neg;
        logic [4:0]       sh;
        logic [2:0][29:0] m30;
        logic [2:0][59:0] sqr;
        logic [30:0]      len;
        logic             len_zero;
        logic [2:0][47:0] q_rem;
        logic [2:0][15:0] q;
        logic [2:0]       q_sat;
        logic [2:0][15:0] o;
        logic [15:0]      wt;
    } pipe_t;

    // reciprocal divider states
    localparam logic [1:0] RCP_IDLE = 2'd0;
    localparam logic [1:0] RCP_LOAD = 2'd1;
    localparam logic [1:0] RCP_RUN  = 2'd2;

    logic [15:0] ratio_reg;
    logic [1:0]  rcp_state_reg, rcp_state_next;
    logic [3:0]  rcp_cnt_reg, rcp_cnt_next;
    logic [31:0] rcp_rem_reg, rcp_rem_next;
    logic [15:0] rcp_q_reg, rcp_q_next;
    logic        rcp_sat_reg, rcp_sat_next;
    logic [15:0] eta_inv;

    logic                   adv;
    logic [rdu_pkg::NSTG-1:0] vld_reg;
    pipe_t                  st_reg  [rdu_pkg::NSTG];
    pipe_t                  st_next [rdu_pkg::NSTG];

    // reflection seen at the output, and its weight/density both zero
    logic                   out_tir;
    logic                   out_quiet;

    // ------------------------------------------------------------------
    // handshakes: one global advance, output register is the last stage
    // ------------------------------------------------------------------
    assign adv       = !vld_reg[rdu_pkg::ST_OUT] || scatter.ready;
    assign ray.ready = adv && (rcp_state_reg == RCP_IDLE);
    assign cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // ratio register and 1/ratio divider (one quotient bit per cycle)
    // eta when entering = (ONE*ONE + r/2) / r, saturated
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= rdu_pkg::RATIO_RESET;
            rcp_state_reg <= RCP_LOAD;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                ratio_reg <= cfg.index_ratio;
            rcp_state_reg <= rcp_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rcp_cnt_reg <= rcp_cnt_next;
        rcp_rem_reg <= rcp_rem_next;
        rcp_q_reg   <= rcp_q_next;
        rcp_sat_reg <= rcp_sat_next;
    end

    always_comb
    begin
        logic [31:0] dsh;
        rcp_state_next = rcp_state_reg;
        rcp_cnt_next   = rcp_cnt_reg;
        rcp_rem_next   = rcp_rem_reg;
        rcp_q_next     = rcp_q_reg;
        rcp_sat_next   = rcp_sat_reg;
        dsh            = 32'(ratio_reg) << rcp_cnt_reg;
        unique case (rcp_state_reg)
            RCP_LOAD:
            begin
                rcp_rem_next   = (32'd1 << (2 * rdu_pkg::FRAC_BITS)) + 32'(ratio_reg >> 1);
                rcp_sat_next   = rcp_rem_next >= {ratio_reg, 16'h0000};
                rcp_q_next     = '0;
                rcp_cnt_next   = 4'd15;
                rcp_state_next = RCP_RUN;
            end
            RCP_RUN:
            begin
                if (rcp_rem_reg >= dsh)
                begin
                    rcp_rem_next             = rcp_rem_reg - dsh;
                    rcp_q_next[rcp_cnt_reg]  = 1'b1;
                end
                rcp_cnt_next = rcp_cnt_reg - 4'd1;
                if (rcp_cnt_reg == 4'd0)
                    rcp_state_next = RCP_IDLE;
            end
            default:
            begin
                rcp_state_next = RCP_IDLE;
            end
        endcase
        // a ratio write restarts the divider
        if (cfg.valid && cfg.ready)
            rcp_state_next = RCP_LOAD;
    end

    assign eta_inv = rcp_sat_reg ? rdu_pkg::ETA_MAX : rcp_q_reg;

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[rdu_pkg::NSTG-2:0], ray.valid && ray.ready};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < rdu_pkg::NSTG; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // stage: capture and component products n*w
    always_comb
    begin
        pipe_t s;
        s      = '0;
        s.n[0] = ray.normal_x;
        s.n[1] = ray.normal_y;
        s.n[2] = ray.normal_z;
        s.w[0] = ray.incoming_x;
        s.w[1] = ray.incoming_y;
        s.w[2] = ray.incoming_z;
        for (int i = 0; i < 3; i++)
            s.prod[i] = 32'(signed'(s.n[i])) * 32'(signed'(s.w[i]));
        st_next[rdu_pkg::ST_PROD] = s;
    end

    // stage: d = N.W
    always_comb
    begin
        pipe_t s;
        s   = st_reg[rdu_pkg::ST_DOT-1];
        s.d = 34'(signed'(s.prod[0])) + 34'(signed'(s.prod[1]))
            + 34'(signed'(s.prod[2]));
        st_next[rdu_pkg::ST_DOT] = s;
    end

    // stage: side, rounded |cos| clamped to one, index ratio for this side
    always_comb
    begin
        pipe_t       s;
        logic [33:0] ad;
        logic [33:0] cr;
        s          = st_reg[rdu_pkg::ST_COS-1];
        s.entering = s.d[33];
        ad         = s.d[33] ? (~s.d + 34'd1) : s.d;
        cr         = (ad + 34'(rdu_pkg::ONE / 2)) >> rdu_pkg::FRAC_BITS;
        s.c        = (cr > 34'(rdu_pkg::ONE)) ? 15'(rdu_pkg::ONE) : cr[14:0];
        s.eta      = s.entering ? eta_inv : ratio_reg;
        st_next[rdu_pkg::ST_COS] = s;
    end

    // stage: c*c, eta*eta, eta*c
    always_comb
    begin
        pipe_t s;
        s      = st_reg[rdu_pkg::ST_SQR-1];
        s.cc   = 29'(30'(s.c) * 30'(s.c));
        s.eta2 = 32'(s.eta) * 32'(s.eta);
        s.ec   = 16'((31'(s.eta) * 31'(s.c)) >> rdu_pkg::FRAC_BITS);
        st_next[rdu_pkg::ST_SQR] = s;
    end

    // stage: squared sine, weight dividend
    always_comb
    begin
        pipe_t s;
        s       = st_reg[rdu_pkg::ST_SIN-1];
        s.s1    = 15'(rdu_pkg::ONE) - s.cc[28:14];
        s.w_rem = 48'({ratio_reg, 8'h00}) + 48'(s.c >> 1);
        s.w_q   = '0;
        st_next[rdu_pkg::ST_SIN] = s;
    end

    // stage: p = eta^2 * s1, weight saturation (also covers c == 0)
    always_comb
    begin
        pipe_t s;
        s       = st_reg[rdu_pkg::ST_PWR-1];
        s.p     = 47'(s.eta2) * 47'(s.s1);
        s.w_sat = s.w_rem >= (48'(s.c) << 16);
        st_next[rdu_pkg::ST_PWR] = s;
    end

    // stage: TIR test p >= ONE^3, cos_t root argument
    always_comb
    begin
        pipe_t s;
        s        = st_reg[rdu_pkg::ST_TIR-1];
        s.tir    = s.p[46:42] != 5'd0;
        s.sq_arg = 64'({15'(rdu_pkg::ONE) - {1'b0, s.p[41:28]}, 14'h0000});
        s.sq     = '0;
        st_next[rdu_pkg::ST_TIR] = s;
    end

    // cos_t = isqrt(arg) two digits a stage; weight quotient alongside
    for (genvar j = 0; j < rdu_pkg::CT_STEPS; j++)
    begin : g_ct
        always_comb
        begin
            pipe_t       s;
            logic [3:0]  qi;
            logic [5:0]  pt;
            logic [47:0] dsh;
            s = st_reg[rdu_pkg::ST_CT+j-1];
            for (int b = 0; b < 2; b++)
            begin
                qi   = 4'(15 - 2 * j - b);
                pt   = 6'({qi, 1'b1});
                s.sq = rdu_pkg::sqrt_step(s.sq, s.sq_arg[pt -: 2]);
                dsh  = 48'(s.c) << qi;
                if (s.w_rem >= dsh)
                begin
                    s.w_rem  = s.w_rem - dsh;
                    s.w_q[qi] = 1'b1;
                end
            end
            st_next[rdu_pkg::ST_CT+j] = s;
        end
    end

    // stage: k = g * ((eta*c >> F) - cos_t)
    always_comb
    begin
        pipe_t       s;
        logic [17:0] kk;
        s   = st_reg[rdu_pkg::ST_KVAL-1];
        kk  = {2'b00, s.ec} - {2'b00, s.sq.root[15:0]};
        s.k = s.entering ? kk : (~kk + 18'd1);
        st_next[rdu_pkg::ST_KVAL] = s;
    end

    // stage: eta*W, k*N, d*N
    always_comb
    begin
        pipe_t s;
        s = st_reg[rdu_pkg::ST_VMUL-1];
        for (int i = 0; i < 3; i++)
        begin
            s.ew[i] = 33'(signed'({1'b0, s.eta})) * 33'(signed'(s.w[i]));
            s.kn[i] = 34'(signed'(s.k)) * 34'(signed'(s.n[i]));
            s.dn[i] = 50'(signed'(s.d)) * 50'(signed'(s.n[i]));
        end
        st_next[rdu_pkg::ST_VMUL] = s;
    end

    // stage: T = mirror or Snell vector
    always_comb
    begin
        pipe_t s;
        s = st_reg[rdu_pkg::ST_VSUM-1];
        for (int i = 0; i < 3; i++)
        begin
            if (s.tir)
                s.t[i] = (51'(signed'(s.w[i])) <<< (2 * rdu_pkg::FRAC_BITS))
                       - (51'(signed'(s.dn[i])) <<< 1);
            else
                s.t[i] = 51'(signed'(s.ew[i])) + 51'(signed'(s.kn[i]));
        end
        st_next[rdu_pkg::ST_VSUM] = s;
    end

    // stage: sign and magnitude
    always_comb
    begin
        pipe_t s;
        s = st_reg[rdu_pkg::ST_MAG-1];
        for (int i = 0; i < 3; i++)
        begin
            s.neg[i] = s.t[i][50];
            s.mag[i] = 50'(s.t[i][50] ? (~s.t[i] + 51'd1) : s.t[i]);
        end
        st_next[rdu_pkg::ST_MAG] = s;
    end

    // stage: common right shift that brings all magnitudes below 2^30
    always_comb
    begin
        pipe_t       s;
        logic [49:0] mor;
        logic [5:0]  bl;
        s   = st_reg[rdu_pkg::ST_SHAMT-1];
        mor = s.mag[0] | s.mag[1] | s.mag[2];
        bl  = '0;
        for (int b = 0; b < 50; b++)
        begin
            if (mor[b])
                bl = 6'(b + 1);
        end
        s.sh = (bl > 6'd30) ? 5'(bl - 6'd30) : 5'd0;
        st_next[rdu_pkg::ST_SHAMT] = s;
    end

    // stage: apply shift
    always_comb
    begin
        pipe_t s;
        s = st_reg[rdu_pkg::ST_SHIFT-1];
        for (int i = 0; i < 3; i++)
            s.m30[i] = 30'(s.mag[i] >> s.sh);
        st_next[rdu_pkg::ST_SHIFT] = s;
    end

    // stage: squares
    always_comb
    begin
        pipe_t s;
        s = st_reg[rdu_pkg::ST_SQUARE-1];
        for (int i = 0; i < 3; i++)
            s.sqr[i] = 60'(s.m30[i]) * 60'(s.m30[i]);
        st_next[rdu_pkg::ST_SQUARE] = s;
    end

    // stage: squared length, root init
    always_comb
    begin
        pipe_t s;
        s        = st_reg[rdu_pkg::ST_LEN2-1];
        s.sq_arg = 64'(s.sqr[0]) + 64'(s.sqr[1]) + 64'(s.sqr[2]);
        s.sq     = '0;
        st_next[rdu_pkg::ST_LEN2] = s;
    end

    // length = isqrt(len2), two digits a stage
    for (genvar j = 0; j < rdu_pkg::LEN_STEPS; j++)
    begin : g_len
        always_comb
        begin
            pipe_t      s;
            logic [4:0] qi;
            logic [5:0] pt;
            s = st_reg[rdu_pkg::ST_LEN+j-1];
            for (int b = 0; b < 2; b++)
            begin
                qi   = 5'(31 - 2 * j - b);
                pt   = {qi, 1'b1};
                s.sq = rdu_pkg::sqrt_step(s.sq, s.sq_arg[pt -: 2]);
            end
            st_next[rdu_pkg::ST_LEN+j] = s;
        end
    end

    // stage: rounded quotient dividends, saturation test
    always_comb
    begin
        pipe_t s;
        s          = st_reg[rdu_pkg::ST_QINIT-1];
        s.len      = s.sq.root[30:0];
        s.len_zero = s.len == 31'd0;
        for (int i = 0; i < 3; i++)
        begin
            s.q_rem[i] = 48'({s.m30[i], 14'h0000}) + 48'(s.len >> 1);
            s.q_sat[i] = s.q_rem[i] >= (48'(s.len) << 16);
            s.q[i]     = '0;
        end
        st_next[rdu_pkg::ST_QINIT] = s;
    end

    // component / length, two quotient bits a stage
    for (genvar j = 0; j < rdu_pkg::QDIV_STEPS; j++)
    begin : g_qdiv
        always_comb
        begin
            pipe_t       s;
            logic [3:0]  qi;
            logic [47:0] dsh;
            s = st_reg[rdu_pkg::ST_QDIV+j-1];
            for (int b = 0; b < 2; b++)
            begin
                qi  = 4'(15 - 2 * j - b);
                dsh = 48'(s.len) << qi;
                for (int i = 0; i < 3; i++)
                begin
                    if (s.q_rem[i] >= dsh)
                    begin
                        s.q_rem[i]   = s.q_rem[i] - dsh;
                        s.q[i][qi]   = 1'b1;
                    end
                end
            end
            st_next[rdu_pkg::ST_QDIV+j] = s;
        end
    end

    // stage: signed clamp of the direction, weight select
    always_comb
    begin
        pipe_t       s;
        logic [16:0] qq;
        s = st_reg[rdu_pkg::ST_OUT-1];
        for (int i = 0; i < 3; i++)
        begin
            if (s.len_zero)
                qq = '0;
            else if (s.q_sat[i])
                qq = 17'h1FFFF;
            else
                qq = {1'b0, s.q[i]};
            if (s.neg[i])
            begin
                if (qq > 17'd32768)
                    qq = 17'd32768;
                s.o[i] = 16'(~qq + 17'd1);
            end
            else
            begin
                if (qq > 17'd32767)
                    qq = 17'd32767;
                s.o[i] = 16'(qq);
            end
        end
        if (s.tir)
            s.wt = '0;
        else
            s.wt = s.w_sat ? rdu_pkg::WEIGHT_MAX : s.w_q;
        st_next[rdu_pkg::ST_OUT] = s;
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign scatter.valid            = vld_reg[rdu_pkg::ST_OUT];
    assign scatter.out_x            = st_reg[rdu_pkg::ST_OUT].o[0];
    assign scatter.out_y            = st_reg[rdu_pkg::ST_OUT].o[1];
    assign scatter.out_z            = st_reg[rdu_pkg::ST_OUT].o[2];
    assign scatter.weight           = st_reg[rdu_pkg::ST_OUT].wt;
    assign scatter.density          = st_reg[rdu_pkg::ST_OUT].tir ?
                                      15'd0 : 15'(rdu_pkg::ONE);
    assign scatter.internal_reflect = st_reg[rdu_pkg::ST_OUT].tir;
    assign scatter.entering_flag    = st_reg[rdu_pkg::ST_OUT].entering;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    assign out_tir   = scatter.valid && scatter.internal_reflect;
    assign out_quiet = (scatter.weight == 16'd0) && (scatter.density == 15'd0);

    `RDU_ASSERT_NXT(a_stall_holds, !adv, $stable(vld_reg), "valids moved in stall")
    `RDU_ASSERT_NXT(a_ray_enters, ray.valid && ray.ready, vld_reg[0], "ray lost at entry")
    `RDU_ASSERT_NXT(a_cfg_reload, cfg.valid && cfg.ready, rcp_state_reg == RCP_LOAD, "no reload")
    `RDU_ASSERT_IMP(a_tir_zero, out_tir, out_quiet, "reflection with weight or density")

endmodule
